// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL. Each one samples on clk and is
// disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/spq_pkg.sv =====
package spq_pkg;

  localparam int PRI_W    = 16;
  localparam int DATA_W   = 32;
  localparam int FILL_W   = 5;
  localparam int STATUS_W = 2;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [PRI_W-1:0]         pri;
    logic signed [DATA_W-1:0] data;
  } entry_t;

  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

// ===== rtl/spq_cell.sv =====
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  logic               valid,
  input  logic               left_take,
  input  spq_pkg::entry_t    left_entry,
  input  spq_pkg::entry_t    right_entry,
  output logic               take,
  output spq_pkg::entry_t    entry
);

  spq_pkg::entry_t entry_r;
  spq_pkg::entry_t entry_nxt;

  // A cell takes part in an insert when it is empty or holds a larger priority;
  // the first such cell loads the new entry, the ones after it shift right.
  assign take  = !valid || (entry_r.pri > ctrl.new_entry.pri);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    priority if (ctrl.ins && take && left_take) begin
      entry_nxt = left_entry;
    end else if (ctrl.ins && take) begin
      entry_nxt = ctrl.new_entry;
    end else if (ctrl.rem) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// Channel   Direction  tdata                                         tuser
// in_       slave      priority_req[15:0], payload[47:16]            op
// out_      master     out_priority[15:0], out_payload[47:16],       status[1:0]
//                      fill_level[52:48], zero[55:53]
//
// The row of cells updates on the clock edge that accepts a beat.
// The result is held in an output register and appears the cycle after acceptance.
// A new beat is taken whenever the output register is empty or being drained.
// Reset is synchronous and active low; it empties the queue and the output register.
// out_tready low stalls the input once a result is waiting.
`include "assert_macros.svh"

module sorted_priority_queue #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // priority_req, payload
  input  logic        in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // out_priority, out_payload, fill_level, zero pad
  output logic [1:0]  out_tuser   // status
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]          count_r;
  logic [CW-1:0]          count_nxt;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  spq_pkg::status_t       status_r;
  spq_pkg::status_t       status_nxt;
  spq_pkg::entry_t        head_r;
  spq_pkg::entry_t        head_nxt;
  logic [spq_pkg::FILL_W-1:0] fill_r;
  logic [spq_pkg::FILL_W-1:0] fill_nxt;
  logic [CW+spq_pkg::FILL_W-1:0] count_ext;

  logic                   accept;
  logic                   is_ins;
  logic                   full;
  logic                   empty;
  spq_pkg::cell_ctrl_t    ctrl;

  logic [DEPTH-1:0]       cell_valid;
  logic [DEPTH-1:0]       cell_take;
  spq_pkg::entry_t        cell_entry [DEPTH];

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign is_ins    = (spq_pkg::op_t'(in_tuser) == spq_pkg::OP_INSERT);
  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);

  assign ctrl.ins            = accept && is_ins && !full;
  assign ctrl.rem            = accept && !is_ins && !empty;
  assign ctrl.new_entry.pri  = in_tdata[15:0];
  assign ctrl.new_entry.data = in_tdata[47:16];

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      localparam logic [CW-1:0] IDX = CW'(i);
      logic            left_take;
      spq_pkg::entry_t left_entry;
      spq_pkg::entry_t right_entry;

      assign cell_valid[i] = (IDX < count_r);

      if (i == 0) begin : g_first
        assign left_take  = 1'b0;
        assign left_entry = ctrl.new_entry;
      end else begin : g_mid
        assign left_take  = cell_take[i-1];
        assign left_entry = cell_entry[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
        assign right_entry = cell_entry[i];
      end else begin : g_inner
        assign right_entry = cell_entry[i+1];
      end

      spq_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .valid       (cell_valid[i]),
        .left_take   (left_take),
        .left_entry  (left_entry),
        .right_entry (right_entry),
        .take        (cell_take[i]),
        .entry       (cell_entry[i])
      );
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    if (ctrl.ins) begin
      count_nxt = count_r + CW'(1);
    end else if (ctrl.rem) begin
      count_nxt = count_r - CW'(1);
    end
    count_ext = {{spq_pkg::FILL_W{1'b0}}, count_nxt};
    fill_nxt  = count_ext[spq_pkg::FILL_W-1:0];

    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    head_nxt      = head_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      head_nxt      = '0;
      status_nxt    = spq_pkg::ST_OK;
      priority if (is_ins && full) begin
        status_nxt = spq_pkg::ST_FULL;
      end else if (!is_ins && empty) begin
        status_nxt = spq_pkg::ST_EMPTY;
      end else if (!is_ins) begin
        head_nxt = cell_entry[0];
      end
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    head_r   <= head_nxt;
    if (accept) begin
      fill_r <= fill_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {3'b000, fill_r, head_r.data, head_r.pri};

  `ASSERT_SAME(a_count_bound, 1'b1, count_r <= CW'(DEPTH))
  `ASSERT_NEXT(a_full_reject, accept && is_ins && full,
               out_tuser == spq_pkg::ST_FULL && count_r == CW'(DEPTH))
  `ASSERT_NEXT(a_empty_remove, accept && !is_ins && empty,
               out_tuser == spq_pkg::ST_EMPTY && count_r == '0)
  `ASSERT_NEXT(a_insert_grows, ctrl.ins, count_r == $past(count_r) + CW'(1))

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int DEPTH       = 16;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    spq_pkg::status_t                  st;
    logic [spq_pkg::PRI_W-1:0]         pri;
    logic signed [spq_pkg::DATA_W-1:0] data;
    logic [spq_pkg::FILL_W-1:0]        fill;
  } pq_result_t;

  typedef struct {
    spq_pkg::op_t               op;
    logic [spq_pkg::PRI_W-1:0]  pri;
    logic [spq_pkg::DATA_W-1:0] data;
    bit                         typed;
    pq_result_t                 res;
  } pq_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;  // priority_req, payload
  logic        in_tuser = 1'b0;  // op
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;  // out_priority, out_payload, fill_level, zero pad
  logic [1:0]  out_tuser;  // status

  spq_pkg::entry_t queue_slots [DEPTH];
  int              queue_count = 0;
  pq_result_t      pending_results [$];
  pq_row_t         directed_rows [$];
  bit              beat_typed = 1'b0;
  pq_result_t      beat_result;
  bit              idle_en = 1'b1;
  int              error_count = 0;
  int              cycle_count = 0;

  sorted_priority_queue #(.DEPTH(DEPTH)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic pq_result_t apply_queue_op(spq_pkg::op_t op,
                                                logic [spq_pkg::PRI_W-1:0] pri,
                                                logic [spq_pkg::DATA_W-1:0] data);
    pq_result_t r;
    int pos;
    r.st   = spq_pkg::ST_OK;
    r.pri  = '0;
    r.data = '0;
    if (op == spq_pkg::OP_INSERT) begin
      if (queue_count >= DEPTH) begin
        r.st = spq_pkg::ST_FULL;
      end else begin
        pos = 0;
        while (pos < queue_count && queue_slots[pos].pri <= pri) pos++;
        for (int k = queue_count; k > pos; k--) queue_slots[k] = queue_slots[k-1];
        queue_slots[pos].pri  = pri;
        queue_slots[pos].data = data;
        queue_count++;
      end
    end else if (queue_count == 0) begin
      r.st = spq_pkg::ST_EMPTY;
    end else begin
      r.pri  = queue_slots[0].pri;
      r.data = queue_slots[0].data;
      for (int k = 1; k < queue_count; k++) queue_slots[k-1] = queue_slots[k];
      queue_count--;
    end
    r.fill = queue_count[spq_pkg::FILL_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, field, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    pq_result_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected beat status", 32'(out_tuser), 32'd0);
        end else begin
          want = pending_results.pop_front();
          if (out_tuser !== want.st)
            report_mismatch("status", 32'(out_tuser), 32'(want.st));
          if (out_tdata[15:0] !== want.pri)
            report_mismatch("priority", 32'(out_tdata[15:0]), 32'(want.pri));
          if (out_tdata[47:16] !== want.data)
            report_mismatch("payload", out_tdata[47:16], want.data);
          if (out_tdata[52:48] !== want.fill)
            report_mismatch("fill level", 32'(out_tdata[52:48]), 32'(want.fill));
        end
      end
      if (in_tvalid && in_tready) begin
        want = apply_queue_op(spq_pkg::op_t'(in_tuser), in_tdata[15:0], in_tdata[47:16]);
        if (beat_typed) want = beat_result;
        pending_results.push_back(want);
      end
    end
  end

  initial begin
    int gap;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      gap = idle_en ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  task automatic send_beat(spq_pkg::op_t op, logic [spq_pkg::PRI_W-1:0] pri,
                           logic [spq_pkg::DATA_W-1:0] data, bit typed, pq_result_t res);
    int gap;
    gap = idle_en ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid   <= 1'b1;
    in_tuser    <= op;
    in_tdata    <= {data, pri};
    beat_typed  <= typed;
    beat_result <= res;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic void add_row(spq_pkg::op_t op, logic [spq_pkg::PRI_W-1:0] pri,
                                  logic [spq_pkg::DATA_W-1:0] data, bit typed,
                                  spq_pkg::status_t st, logic [spq_pkg::PRI_W-1:0] rpri,
                                  logic [spq_pkg::DATA_W-1:0] rdata, int fill);
    pq_row_t row;
    row.op       = op;
    row.pri      = pri;
    row.data     = data;
    row.typed    = typed;
    row.res.st   = st;
    row.res.pri  = rpri;
    row.res.data = rdata;
    row.res.fill = fill[spq_pkg::FILL_W-1:0];
    directed_rows.push_back(row);
  endfunction

  initial begin
    pq_result_t none;
    int         ins_pct;
    int         pri_mode;
    logic [spq_pkg::PRI_W-1:0]  pri;
    logic [spq_pkg::DATA_W-1:0] data;
    spq_pkg::op_t op;

    none = '{spq_pkg::ST_OK, '0, '0, '0};
    add_row(spq_pkg::OP_REMOVE, 16'h0000, 32'h0, 1, spq_pkg::ST_EMPTY, 16'h0, 32'h0, 0);
    add_row(spq_pkg::OP_INSERT, 16'hFFFF, 32'h7FFFFFFF, 1, spq_pkg::ST_OK, 16'h0, 32'h0, 1);
    add_row(spq_pkg::OP_INSERT, 16'h0000, 32'h80000000, 1, spq_pkg::ST_OK, 16'h0, 32'h0, 2);
    add_row(spq_pkg::OP_REMOVE, 16'hFFFF, 32'hFFFFFFFF, 1, spq_pkg::ST_OK,
            16'h0000, 32'h80000000, 1);
    add_row(spq_pkg::OP_REMOVE, 16'h0000, 32'h0, 1, spq_pkg::ST_OK,
            16'hFFFF, 32'h7FFFFFFF, 0);
    add_row(spq_pkg::OP_REMOVE, 16'h0000, 32'h0, 1, spq_pkg::ST_EMPTY, 16'h0, 32'h0, 0);
    // Equal priorities must leave in the order they arrived.
    for (int n = 1; n <= 3; n++)
      add_row(spq_pkg::OP_INSERT, 16'h1234, 32'(n), 1, spq_pkg::ST_OK, 16'h0, 32'h0, n);
    add_row(spq_pkg::OP_REMOVE, 16'h0, 32'h0, 0, spq_pkg::ST_OK, 16'h0, 32'h0, 0);
    for (int n = 3; n <= DEPTH; n++)
      add_row(spq_pkg::OP_INSERT, 16'(n * 4099), 32'(n * 32'h1111_1111), 1,
              spq_pkg::ST_OK, 16'h0, 32'h0, n);
    add_row(spq_pkg::OP_INSERT, 16'h0001, 32'hDEADBEEF, 1, spq_pkg::ST_FULL,
            16'h0, 32'h0, DEPTH);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      send_beat(directed_rows[i].op, directed_rows[i].pri, directed_rows[i].data,
                directed_rows[i].typed, directed_rows[i].res);

    for (int phase = 0; phase < 12; phase++) begin
      wait_for_results();
      idle_en  = (phase % 4) != 3;
      ins_pct  = (phase % 3 == 0) ? 80 : (phase % 3 == 1) ? 20 : 50;
      pri_mode = $urandom_range(0, 2);
      for (int n = 0; n < 96; n++) begin
        op = ($urandom_range(0, 99) < ins_pct) ? spq_pkg::OP_INSERT : spq_pkg::OP_REMOVE;
        case (pri_mode)
          0: pri = 16'($urandom);
          1: pri = 16'($urandom_range(0, 3));
          default: pri = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        endcase
        data = $urandom;
        if ($urandom_range(0, 15) == 0) data = $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
        send_beat(op, pri, data, 0, none);
      end
    end

    beat_typed <= 1'b0;
    wait_for_results();
    repeat (5) @(negedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
tb/tb.sv
